/* hw/rtl/catmull_rom_point_interpolator_core_defines.svh */
// Assertion macros shared by the interpolator RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef CATMULL_ROM_POINT_INTERPOLATOR_CORE_DEFINES_SVH
`define CATMULL_ROM_POINT_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising clock edge outside reset.
`define CRPI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("crpi: assertion failed");
// Checked at every rising clock edge, reset included.
`define CRPI_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("crpi: assertion failed");
`else
`define CRPI_ASSERT(lbl, clk, rst, prop)
`define CRPI_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/crpi_pkg.sv */
package crpi_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int PHASE_WIDTH = 16;

   // Register stages from an accepted request to its response strobe.
   localparam int AXIS_LATENCY = 8;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] prev_x;
      logic signed [COORD_WIDTH-1:0] prev_y;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] next_x;
      logic signed [COORD_WIDTH-1:0] next_y;
      logic        [PHASE_WIDTH-1:0] phase;
   } crpi_req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          clipped;
   } crpi_rsp_type;

   // Control points of one axis.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pt_prev;
      logic signed [COORD_WIDTH-1:0] pt_start;
      logic signed [COORD_WIDTH-1:0] pt_end;
      logic signed [COORD_WIDTH-1:0] pt_next;
   } crpi_axis_in_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point;
      logic                          clip;
   } crpi_axis_out_type;

endpackage

/* hw/rtl/crpi_axis.sv */
module crpi_axis (
   input  logic                             clock,
   input  crpi_pkg::crpi_axis_in_type       pts,
   input  logic [crpi_pkg::PHASE_WIDTH-1:0] phase,
   output crpi_pkg::crpi_axis_out_type      result
);
   import crpi_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int PW     = PHASE_WIDTH;
   localparam int C0_W   = CW + 3;
   localparam int C1_W   = CW + 4;
   localparam int C2_W   = CW + 1;
   localparam int M0_W   = C0_W + PW + 1;
   localparam int W1     = M0_W + 1;
   localparam int L1     = W1 / 2;
   localparam int PLO1_W = L1 + PW;
   localparam int PHI1_W = (W1 - L1) + PW + 1;
   localparam int W2     = CW + 2 * PW + 7;
   localparam int L2     = W2 / 2;
   localparam int PLO2_W = L2 + PW;
   localparam int PHI2_W = (W2 - L2) + PW + 1;
   localparam int W3     = CW + 3 * PW + 9;
   localparam int FRAC   = 3 * PW + 1;
   localparam int R_W    = W3 - FRAC;

   // Stage 1: doubled Catmull-Rom coefficients.
   logic signed [C0_W-1:0]   c0_ff, c0_in;
   logic signed [C1_W-1:0]   c1_s1_ff, c1_s1_in;
   logic signed [C2_W-1:0]   c2_s1_ff, c2_s1_in;
   logic signed [CW-1:0]     st_s1_ff, st_s1_in;
   logic        [PW-1:0]     ph_s1_ff, ph_s1_in;
   logic signed [C0_W-1:0]   diff_se;
   // Stage 2: c0 * t.
   logic signed [M0_W-1:0]   m0_ff, m0_in;
   logic signed [C1_W-1:0]   c1_s2_ff, c1_s2_in;
   logic signed [C2_W-1:0]   c2_s2_ff, c2_s2_in;
   logic signed [CW-1:0]     st_s2_ff, st_s2_in;
   logic        [PW-1:0]     ph_s2_ff, ph_s2_in;
   // Stage 3: first Horner sum.
   logic signed [W1-1:0]     h1_ff, h1_in;
   logic signed [C2_W-1:0]   c2_s3_ff, c2_s3_in;
   logic signed [CW-1:0]     st_s3_ff, st_s3_in;
   logic        [PW-1:0]     ph_s3_ff, ph_s3_in;
   // Stage 4: split product h1 * t.
   logic        [PLO1_W-1:0] plo1_ff, plo1_in;
   logic signed [PHI1_W-1:0] phi1_ff, phi1_in;
   logic signed [C2_W-1:0]   c2_s4_ff, c2_s4_in;
   logic signed [CW-1:0]     st_s4_ff, st_s4_in;
   logic        [PW-1:0]     ph_s4_ff, ph_s4_in;
   // Stage 5: second Horner sum.
   logic signed [W2-1:0]     h2_ff, h2_in;
   logic signed [CW-1:0]     st_s5_ff, st_s5_in;
   logic        [PW-1:0]     ph_s5_ff, ph_s5_in;
   // Stage 6: split product h2 * t.
   logic        [PLO2_W-1:0] plo2_ff, plo2_in;
   logic signed [PHI2_W-1:0] phi2_ff, phi2_in;
   logic signed [CW-1:0]     st_s6_ff, st_s6_in;
   // Stage 7: full scaled value with the rounding half folded in.
   logic signed [W3-1:0]     acc_ff, acc_in;
   // Stage 8: rounded and saturated point.
   logic signed [R_W-1:0]    rounded;
   logic signed [CW-1:0]     point_ff, point_in;
   logic                     clip_ff, clip_in;

   always_comb begin
      diff_se  = C0_W'(pts.pt_start) - C0_W'(pts.pt_end);
      c0_in    = C0_W'(pts.pt_next) - C0_W'(pts.pt_prev) + (diff_se <<< 1) + diff_se;
      c1_s1_in = (C1_W'(pts.pt_prev) <<< 1) - (C1_W'(pts.pt_start) <<< 2)
                 - C1_W'(pts.pt_start) + (C1_W'(pts.pt_end) <<< 2) - C1_W'(pts.pt_next);
      c2_s1_in = C2_W'(pts.pt_end) - C2_W'(pts.pt_prev);
      st_s1_in = pts.pt_start;
      ph_s1_in = phase;

      m0_in    = M0_W'(c0_ff) * M0_W'($signed({1'b0, ph_s1_ff}));
      c1_s2_in = c1_s1_ff;
      c2_s2_in = c2_s1_ff;
      st_s2_in = st_s1_ff;
      ph_s2_in = ph_s1_ff;

      h1_in    = W1'(m0_ff) + (W1'(c1_s2_ff) <<< PW);
      c2_s3_in = c2_s2_ff;
      st_s3_in = st_s2_ff;
      ph_s3_in = ph_s2_ff;

      // The wide operand is cut into an unsigned low part and a signed high part.
      plo1_in  = PLO1_W'(h1_ff[L1-1:0]) * PLO1_W'(ph_s3_ff);
      phi1_in  = PHI1_W'($signed(h1_ff[W1-1:L1])) * PHI1_W'($signed({1'b0, ph_s3_ff}));
      c2_s4_in = c2_s3_ff;
      st_s4_in = st_s3_ff;
      ph_s4_in = ph_s3_ff;

      h2_in    = (W2'(phi1_ff) <<< L1) + W2'($signed({1'b0, plo1_ff}))
                 + (W2'(c2_s4_ff) <<< (2 * PW));
      st_s5_in = st_s4_ff;
      ph_s5_in = ph_s4_ff;

      plo2_in  = PLO2_W'(h2_ff[L2-1:0]) * PLO2_W'(ph_s5_ff);
      phi2_in  = PHI2_W'($signed(h2_ff[W2-1:L2])) * PHI2_W'($signed({1'b0, ph_s5_ff}));
      st_s6_in = st_s5_ff;

      // The start term and the rounding half share one operand: start, then a one,
      // then the fraction zeros.
      acc_in   = (W3'(phi2_ff) <<< L2) + W3'($signed({1'b0, plo2_ff}))
                 + W3'($signed({st_s6_ff, 1'b1, {(3 * PW){1'b0}}}));

      rounded  = $signed(acc_ff[W3-1:FRAC]);
      if (rounded > R_W'(COORD_MAX)) begin
         point_in = COORD_MAX;
         clip_in  = 1'b1;
      end else if (rounded < R_W'(COORD_MIN)) begin
         point_in = COORD_MIN;
         clip_in  = 1'b1;
      end else begin
         point_in = rounded[CW-1:0];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff    <= c0_in;
      c1_s1_ff <= c1_s1_in;
      c2_s1_ff <= c2_s1_in;
      st_s1_ff <= st_s1_in;
      ph_s1_ff <= ph_s1_in;
      m0_ff    <= m0_in;
      c1_s2_ff <= c1_s2_in;
      c2_s2_ff <= c2_s2_in;
      st_s2_ff <= st_s2_in;
      ph_s2_ff <= ph_s2_in;
      h1_ff    <= h1_in;
      c2_s3_ff <= c2_s3_in;
      st_s3_ff <= st_s3_in;
      ph_s3_ff <= ph_s3_in;
      plo1_ff  <= plo1_in;
      phi1_ff  <= phi1_in;
      c2_s4_ff <= c2_s4_in;
      st_s4_ff <= st_s4_in;
      ph_s4_ff <= ph_s4_in;
      h2_ff    <= h2_in;
      st_s5_ff <= st_s5_in;
      ph_s5_ff <= ph_s5_in;
      plo2_ff  <= plo2_in;
      phi2_ff  <= phi2_in;
      st_s6_ff <= st_s6_in;
      acc_ff   <= acc_in;
      point_ff <= point_in;
      clip_ff  <= clip_in;
   end

   assign result.point = point_ff;
   assign result.clip  = clip_ff;

endmodule

/* hw/rtl/catmull_rom_point_interpolator_core.sv */
// Catmull-Rom point interpolator: a request is transferred at a rising clock edge where
// start is high and busy is low. One response appears on rsp_payload for exactly one
// cycle, marked by rsp_valid, once the request has passed through the two eight-stage
// axis pipelines, each with three multiplier stages evaluating the cubic in Horner form.
// A new request may be transferred in every cycle, so the block sustains one point per
// clock. Responses cannot be held off and the pipeline never stalls.
// busy is high only during reset. The result is rounded to nearest (halves toward plus
// infinity) and saturated to the coordinate range, with clipped set if either axis
// saturated.
`include "catmull_rom_point_interpolator_core_defines.svh"

module catmull_rom_point_interpolator_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  crpi_pkg::crpi_req_type req_payload,
   output logic                   rsp_valid,
   output crpi_pkg::crpi_rsp_type rsp_payload
);
   import crpi_pkg::*;

   logic [AXIS_LATENCY-1:0] valid_ff, valid_in;
   crpi_axis_in_type        axis_x_in, axis_y_in;
   crpi_axis_out_type       axis_x_out, axis_y_out;
   logic                    rsp_at_bound;

   assign busy = reset;

   assign axis_x_in.pt_prev  = req_payload.prev_x;
   assign axis_x_in.pt_start = req_payload.start_x;
   assign axis_x_in.pt_end   = req_payload.end_x;
   assign axis_x_in.pt_next  = req_payload.next_x;
   assign axis_y_in.pt_prev  = req_payload.prev_y;
   assign axis_y_in.pt_start = req_payload.start_y;
   assign axis_y_in.pt_end   = req_payload.end_y;
   assign axis_y_in.pt_next  = req_payload.next_y;

   crpi_axis axis_x (
      .clock  (clock),
      .pts    (axis_x_in),
      .phase  (req_payload.phase),
      .result (axis_x_out)
   );

   crpi_axis axis_y (
      .clock  (clock),
      .pts    (axis_y_in),
      .phase  (req_payload.phase),
      .result (axis_y_out)
   );

   // One valid bit per stage travels alongside the axis datapaths.
   assign valid_in = {valid_ff[AXIS_LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff[AXIS_LATENCY-1];
   assign rsp_payload.point_x = axis_x_out.point;
   assign rsp_payload.point_y = axis_y_out.point;
   assign rsp_payload.clipped = axis_x_out.clip | axis_y_out.clip;

   assign rsp_at_bound = (rsp_payload.point_x == COORD_MAX) || (rsp_payload.point_x == COORD_MIN)
                         || (rsp_payload.point_y == COORD_MAX)
                         || (rsp_payload.point_y == COORD_MIN);

   `CRPI_ASSERT_ALWAYS(a_reset_flushes_rsp, clock, reset |=> !rsp_valid)
   `CRPI_ASSERT(a_clip_at_bound, clock, reset, rsp_valid && rsp_payload.clipped |-> rsp_at_bound)

endmodule

/* verif/crpi_checker.sv */
`timescale 1ns / 100ps

module crpi_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  crpi_pkg::crpi_req_type req_payload,
   input  logic                   rsp_valid,
   input  crpi_pkg::crpi_rsp_type rsp_payload,
   output int unsigned            error_count,
   output int unsigned            pending_count
);
   import crpi_pkg::*;

   crpi_rsp_type expected_pts[$];
   int unsigned  mismatches = 0;

   // The cubic is evaluated exactly on doubled coefficients at 128 bits, then rounded once.
   function automatic crpi_axis_out_type eval_axis(crpi_axis_in_type pts,
                                                   logic [PHASE_WIDTH-1:0] ph);
      logic signed [127:0] pv, st, en, nx, t;
      logic signed [127:0] c0, c1, c2, acc, rnd;
      crpi_axis_out_type   res;
      pv  = $signed(pts.pt_prev);
      st  = $signed(pts.pt_start);
      en  = $signed(pts.pt_end);
      nx  = $signed(pts.pt_next);
      t   = {{(128-PHASE_WIDTH){1'b0}}, ph};
      c0  = -pv + 3 * st - 3 * en + nx;
      c1  = 2 * pv - 5 * st + 4 * en - nx;
      c2  = en - pv;
      acc = c0 * t + (c1 <<< PHASE_WIDTH);
      acc = acc * t + (c2 <<< (2 * PHASE_WIDTH));
      acc = acc * t + (st <<< (3 * PHASE_WIDTH + 1)) + (128'sd1 <<< (3 * PHASE_WIDTH));
      rnd = acc >>> (3 * PHASE_WIDTH + 1);
      res.clip = 1'b0;
      if (rnd > $signed(COORD_MAX)) begin
         rnd      = $signed(COORD_MAX);
         res.clip = 1'b1;
      end else if (rnd < $signed(COORD_MIN)) begin
         rnd      = $signed(COORD_MIN);
         res.clip = 1'b1;
      end
      res.point = rnd[COORD_WIDTH-1:0];
      return res;
   endfunction

   function automatic crpi_rsp_type predict_point(crpi_req_type rq);
      crpi_axis_out_type ax, ay;
      crpi_rsp_type      res;
      ax = eval_axis({rq.prev_x, rq.start_x, rq.end_x, rq.next_x}, rq.phase);
      ay = eval_axis({rq.prev_y, rq.start_y, rq.end_y, rq.next_y}, rq.phase);
      res.point_x = ax.point;
      res.point_y = ay.point;
      res.clipped = ax.clip | ay.clip;
      return res;
   endfunction

   always @(posedge clock) begin
      crpi_rsp_type want;
      if (!reset) begin
         if (start && !busy)
            expected_pts.push_back(predict_point(req_payload));
         if (rsp_valid) begin
            if (expected_pts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response x=%0d y=%0d clipped=%0b", $realtime,
                           rsp_payload.point_x, rsp_payload.point_y, rsp_payload.clipped);
            end else begin
               want = expected_pts.pop_front();
               if (rsp_payload.point_x !== want.point_x || rsp_payload.point_y !== want.point_y
                   || rsp_payload.clipped !== want.clipped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: point mismatch: expected x=%0d y=%0d clipped=%0b, ",
                              $realtime, want.point_x, want.point_y, want.clipped,
                              "got x=%0d y=%0d clipped=%0b",
                              rsp_payload.point_x, rsp_payload.point_y, rsp_payload.clipped);
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_pts.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import crpi_pkg::*;

   localparam int RANDOM_POINTS = 1700;
   localparam int CALM_TAIL     = 200;
   localparam int CYCLE_LIMIT   = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   crpi_req_type req_payload = '0;
   logic         rsp_valid;
   crpi_rsp_type rsp_payload;
   int unsigned  error_count;
   int unsigned  pending_count;
   int unsigned  cycles = 0;

   catmull_rom_point_interpolator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   crpi_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Holds the request until the block takes it; start is left high for the caller.
   task automatic transfer_point(crpi_req_type rq);
      req_payload <= rq;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_pt(logic signed [COORD_WIDTH-1:0] px, logic signed [COORD_WIDTH-1:0] py,
                          logic signed [COORD_WIDTH-1:0] sx, logic signed [COORD_WIDTH-1:0] sy,
                          logic signed [COORD_WIDTH-1:0] ex, logic signed [COORD_WIDTH-1:0] ey,
                          logic signed [COORD_WIDTH-1:0] nx, logic signed [COORD_WIDTH-1:0] ny,
                          logic [PHASE_WIDTH-1:0] ph);
      crpi_req_type rq;
      rq = '{px, py, sx, sy, ex, ey, nx, ny, ph};
      transfer_point(rq);
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      logic signed [COORD_WIDTH-1:0] v;
      v = COORD_WIDTH'($urandom);
      case ($urandom_range(0, 3))
         0: v = v;
         1: v = v >>> $urandom_range(1, COORD_WIDTH - 1);
         2: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $signed(COORD_WIDTH'($urandom_range(0, 200))) - COORD_WIDTH'(100);
      endcase
      return v;
   endfunction

   // Either four unrelated points or a gently varying sequence around a random base.
   function automatic crpi_axis_in_type rand_axis();
      crpi_axis_in_type pts;
      logic signed [COORD_WIDTH-1:0] base;
      int unsigned step_bits;
      if ($urandom_range(0, 1)) begin
         pts = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      end else begin
         base      = COORD_WIDTH'($urandom);
         step_bits = $urandom_range(2, 18);
         pts.pt_prev  = base;
         pts.pt_start = pts.pt_prev + ($signed(COORD_WIDTH'($urandom)) >>> (COORD_WIDTH - step_bits));
         pts.pt_end   = pts.pt_start + ($signed(COORD_WIDTH'($urandom)) >>> (COORD_WIDTH - step_bits));
         pts.pt_next  = pts.pt_end + ($signed(COORD_WIDTH'($urandom)) >>> (COORD_WIDTH - step_bits));
      end
      return pts;
   endfunction

   function automatic logic [PHASE_WIDTH-1:0] rand_phase();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return PHASE_WIDTH'($urandom_range(1, 15));
         default: return PHASE_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      crpi_req_type     rq;
      crpi_axis_in_type ax, ay;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pt('0, '0, '0, '0, '0, '0, '0, '0, '0);
      send_pt(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MAX, COORD_MAX, '1);
      send_pt(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MIN, COORD_MIN, '1);
      // Overshoot past the top and bottom of the range on both axes.
      send_pt(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              COORD_MIN, COORD_MIN, 16'h8000);
      send_pt(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MAX, COORD_MAX, 16'h8000);
      send_pt(COORD_MIN, '0, COORD_MAX, '0, COORD_MAX, '0, COORD_MIN, '0, 16'h8000);
      send_pt('0, COORD_MAX, '0, COORD_MIN, '0, COORD_MIN, '0, COORD_MAX, 16'h8000);
      // At t = 1/2 these give exactly -0.5 on one axis and +0.5 on the other.
      send_pt('0, '0, '0, '0, '0, '0, 24'sd8, -24'sd8, 16'h8000);
      send_pt('0, '0, '0, '0, '0, '0, -24'sd8, 24'sd8, 16'h8000);
      // With zero phase the start point comes back untouched, however wild the others.
      send_pt(COORD_MIN, COORD_MAX, 24'sd123, -24'sd456, COORD_MAX, COORD_MIN,
              COORD_MIN, COORD_MAX, '0);
      send_pt(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
              COORD_MIN, COORD_MAX, '0);
      send_pt(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
              COORD_MAX, COORD_MIN, 16'h0001);
      send_pt(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
              COORD_MIN, COORD_MAX, '1);
      send_pt(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA,
              24'hAAAAAA, 24'h555555, 16'h5555);
      send_pt(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
              24'h555555, 24'hAAAAAA, 16'hAAAA);
      send_pt(-24'sd100, 24'sd300, '0, 24'sd200, 24'sd100, 24'sd100, 24'sd200, '0,
              16'h4000);
      send_pt(-24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1,
              16'hC000);
      send_pt(24'sd1, '0, '0, '0, '0, '0, '0, 24'sd1, 16'h0001);
      start <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < RANDOM_POINTS; i++) begin
         ax = rand_axis();
         ay = rand_axis();
         rq = '{ax.pt_prev, ay.pt_prev, ax.pt_start, ay.pt_start, ax.pt_end, ay.pt_end,
                ax.pt_next, ay.pt_next, rand_phase()};
         transfer_point(rq);
         if (i < RANDOM_POINTS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (AXIS_LATENCY + 4) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
